// ----- sv/mcst_pkg.sv -----
// Shared constants and types for the multi-channel timer pool.
// Field widths, stream packing, command and status codes.
// No dependencies.
package mcst_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIMER_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_EVENTS = 16;
    localparam int NEV_W      = $clog2(MAX_EVENTS + 1);

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 56;

    typedef logic [TIMER_W-1:0] t_idx;
    typedef logic [1:0]         t_tstate;

    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_DELETE = 3'd3;
    localparam logic [2:0] ACT_TICK   = 3'd4;
    localparam logic [2:0] ACT_QUERY  = 3'd5;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_EMPTY    = 2'd1;
    localparam logic [1:0] STS_NOTALLOC = 2'd2;
    localparam logic [1:0] STS_INVALID  = 2'd3;

    localparam t_tstate TS_UNUSED    = 2'd0;
    localparam t_tstate TS_STOPPED   = 2'd1;
    localparam t_tstate TS_RUNNING   = 2'd2;
    localparam t_tstate TS_COMPLETED = 2'd3;

    localparam logic [1:0] OPT_STORED = 2'd1;
    localparam logic [1:0] OPT_GIVEN  = 2'd2;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

endpackage

// ----- sv/multi_channel_software_timer.sv -----
// Timer pool with a command-driven tick counter and a shared 32-bit adder.
// Command reply loaded into the output register in EXEC (stop event first, reply
// from REPLY); tick: one timer per cycle unless an event is stalled, then a reply.
// Output stalls add cycles; the input is not ready while an item is in progress.
// Reset (sync, active low) clears the tick count and marks all timers unused;
// per-timer settings are undefined until written, no clearing pass.
module multi_channel_software_timer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tmr_sel[3:0], delay[35:4], period[67:36], periodic[68],
    // has_callback[69], arg[85:70], stop_option[87:86]
    input  logic [mcst_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // action[2:0]
    input  logic [mcst_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tmr_num[3:0], status[5:4], timer_state[7:6], remaining[39:8],
    // evt_arg[55:40]
    output logic [mcst_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // kind[0]
    output logic                             o_m_axis_tuser,
    output logic                             o_m_axis_tlast
);
    import mcst_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_REPLY = 2'd3;

    localparam t_idx LAST_IDX = t_idx'(NUM_TIMERS - 1);

    logic [1:0]  r_state, n_state;
    logic [31:0] r_tick, n_tick;
    t_idx        r_idx, n_idx;
    logic [NEV_W-1:0] r_nev, n_nev;
    logic [3:0]  r_rep_id, n_rep_id;
    t_tstate     r_rep_state, n_rep_state;

    // latched command
    logic [2:0]  r_action;
    logic [3:0]  r_id;
    logic [31:0] r_delay;
    logic [31:0] r_period_in;
    logic        r_periodic_in;
    logic        r_cb_in;
    logic [15:0] r_arg;
    logic [1:0]  r_opt;

    // per-timer storage
    t_tstate     r_status [NUM_TIMERS];
    logic [31:0] r_match  [NUM_TIMERS];
    logic [31:0] r_dly    [NUM_TIMERS];
    logic [31:0] r_per    [NUM_TIMERS];
    logic        r_mode   [NUM_TIMERS];
    logic        r_cben   [NUM_TIMERS];
    logic [15:0] r_sarg   [NUM_TIMERS];

    // output register
    logic        r_out_valid;
    logic        r_o_kind;
    logic [3:0]  r_o_id;
    logic [1:0]  r_o_status;
    t_tstate     r_o_state;
    logic [31:0] r_o_rem;
    logic [15:0] r_o_arg;
    logic        r_o_last;

    logic        slot_free;
    logic        in_xfer;
    logic [31:0] id_wide;
    logic        id_ok;
    t_idx        id_idx;
    t_idx        rd_idx;
    t_tstate     cur_status;
    logic [31:0] cur_match;
    logic [31:0] cur_per;
    logic        cur_mode;
    logic        cur_cb;
    logic        id_valid;
    logic        free_found;
    t_idx        free_idx;

    logic [31:0] add_a, add_b, add_y;
    logic        add_sub;

    logic        hit;
    logic        ev;

    logic        out_load;
    logic        out_kind;
    logic [3:0]  out_id;
    logic [1:0]  out_status;
    t_tstate     out_state;
    logic [31:0] out_rem;
    logic [15:0] out_arg;
    logic        out_last;

    logic        st_we;
    t_tstate     st_data;
    logic        match_we;
    logic        create_we;
    logic        del_we;
    t_idx        wr_addr;

    assign slot_free       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    assign id_wide    = 32'(r_id);
    assign id_ok      = id_wide < NUM_TIMERS;
    assign id_idx     = t_idx'(id_wide);
    assign rd_idx     = (r_state == S_SCAN) ? r_idx : id_idx;
    assign cur_status = r_status[rd_idx];
    assign cur_match  = r_match[rd_idx];
    assign cur_per    = r_per[rd_idx];
    assign cur_mode   = r_mode[rd_idx];
    assign cur_cb     = r_cben[rd_idx];
    assign id_valid   = id_ok && (cur_status != TS_UNUSED);

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (r_status[i] == TS_UNUSED) begin
                free_found = 1'b1;
                free_idx   = t_idx'(i);
            end
        end
    end

    // shared adder: match = tick + reload, remaining = match - tick
    always_comb begin
        add_a   = cur_match;
        add_b   = r_tick;
        add_sub = 1'b1;
        if (r_state == S_SCAN) begin
            add_a   = cur_per;
            add_b   = r_tick;
            add_sub = 1'b0;
        end else if (r_action == ACT_START) begin
            add_a   = r_tick;
            add_b   = cur_mode ? cur_per : r_dly[rd_idx];
            add_sub = 1'b0;
        end
    end
    assign add_y = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};

    assign hit = (cur_status == TS_RUNNING) && (cur_match == r_tick);
    assign ev  = hit && cur_cb && (r_nev < NEV_W'(MAX_EVENTS));

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_idx       = r_idx;
        n_nev       = r_nev;
        n_rep_id    = r_rep_id;
        n_rep_state = r_rep_state;
        out_load    = 1'b0;
        out_kind    = KIND_REPLY;
        out_id      = r_id;
        out_status  = STS_OK;
        out_state   = TS_UNUSED;
        out_rem     = '0;
        out_arg     = '0;
        out_last    = 1'b1;
        st_we       = 1'b0;
        st_data     = TS_UNUSED;
        match_we    = 1'b0;
        create_we   = 1'b0;
        del_we      = 1'b0;
        wr_addr     = rd_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_action == ACT_TICK) begin
                    n_tick  = r_tick + 32'd1;
                    n_idx   = '0;
                    n_nev   = '0;
                    n_state = S_SCAN;
                end else if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    unique case (r_action)
                        ACT_CREATE: begin
                            if (free_found) begin
                                wr_addr   = free_idx;
                                create_we = 1'b1;
                                st_we     = 1'b1;
                                st_data   = TS_STOPPED;
                                out_id    = 4'(32'(free_idx));
                                out_state = TS_STOPPED;
                            end else begin
                                out_id     = '0;
                                out_status = STS_EMPTY;
                            end
                        end
                        ACT_START: begin
                            if (id_valid) begin
                                match_we  = (cur_status != TS_RUNNING);
                                st_we     = 1'b1;
                                st_data   = TS_RUNNING;
                                out_state = TS_RUNNING;
                            end else begin
                                out_status = STS_NOTALLOC;
                            end
                        end
                        ACT_STOP: begin
                            if (id_valid) begin
                                st_we     = 1'b1;
                                st_data   = TS_STOPPED;
                                out_state = TS_STOPPED;
                                if (cur_cb && (r_opt == OPT_STORED || r_opt == OPT_GIVEN)) begin
                                    out_kind    = KIND_EVENT;
                                    out_rem     = add_y;
                                    out_arg     = (r_opt == OPT_STORED) ? r_sarg[rd_idx]
                                                                         : r_arg;
                                    out_last    = 1'b0;
                                    n_rep_id    = r_id;
                                    n_rep_state = TS_STOPPED;
                                    n_state     = S_REPLY;
                                end
                            end else begin
                                out_status = STS_NOTALLOC;
                            end
                        end
                        ACT_DELETE: begin
                            if (id_valid) begin
                                st_we  = 1'b1;
                                del_we = 1'b1;
                            end else begin
                                out_status = STS_NOTALLOC;
                            end
                        end
                        ACT_QUERY: begin
                            if (id_valid) begin
                                out_state = cur_status;
                                out_rem   = add_y;
                            end else begin
                                out_status = STS_NOTALLOC;
                            end
                        end
                        default: begin
                            out_status = STS_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!ev || slot_free) begin
                    if (hit) begin
                        if (cur_mode) begin
                            match_we = 1'b1;
                        end else begin
                            st_we   = 1'b1;
                            st_data = TS_COMPLETED;
                        end
                    end
                    if (ev) begin
                        out_load  = 1'b1;
                        out_kind  = KIND_EVENT;
                        out_id    = 4'(32'(r_idx));
                        out_state = cur_mode ? TS_RUNNING : TS_COMPLETED;
                        out_rem   = cur_mode ? cur_per : 32'd0;
                        out_arg   = r_sarg[rd_idx];
                        out_last  = 1'b0;
                        n_nev     = r_nev + NEV_W'(1);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_rep_id    = '0;
                        n_rep_state = TS_UNUSED;
                        n_state     = S_REPLY;
                    end else begin
                        n_idx = r_idx + t_idx'(1);
                    end
                end
            end
            S_REPLY: begin
                if (slot_free) begin
                    out_load  = 1'b1;
                    out_id    = r_rep_id;
                    out_state = r_rep_state;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_status[i] <= TS_UNUSED;
            end
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            if (st_we) begin
                r_status[wr_addr] <= st_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_nev       <= n_nev;
        r_rep_id    <= n_rep_id;
        r_rep_state <= n_rep_state;
        if (in_xfer) begin
            r_action      <= i_s_axis_tuser;
            r_id          <= i_s_axis_tdata[3:0];
            r_delay       <= i_s_axis_tdata[35:4];
            r_period_in   <= i_s_axis_tdata[67:36];
            r_periodic_in <= i_s_axis_tdata[68];
            r_cb_in       <= i_s_axis_tdata[69];
            r_arg         <= i_s_axis_tdata[85:70];
            r_opt         <= i_s_axis_tdata[87:86];
        end
        if (match_we) begin
            r_match[wr_addr] <= add_y;
        end
        if (create_we) begin
            r_dly[wr_addr]  <= r_delay;
            r_per[wr_addr]  <= r_period_in;
            r_mode[wr_addr] <= r_periodic_in;
            r_cben[wr_addr] <= r_cb_in;
            r_sarg[wr_addr] <= r_arg;
        end else if (del_we) begin
            r_mode[wr_addr] <= 1'b0;
            r_cben[wr_addr] <= 1'b0;
        end
        if (out_load) begin
            r_o_kind   <= out_kind;
            r_o_id     <= out_id;
            r_o_status <= out_status;
            r_o_state  <= out_state;
            r_o_rem    <= out_rem;
            r_o_arg    <= out_arg;
            r_o_last   <= out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_o_arg, r_o_rem, r_o_state, r_o_status, r_o_id};
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_accept_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EXEC))
        else $error("command transfer did not enter execution");

    a_tick_inc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_action == ACT_TICK) |=> (r_tick == $past(r_tick) + 32'd1))
        else $error("tick counter did not advance by one");

    a_event_not_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> !o_m_axis_tlast)
        else $error("callback event flagged as last result");

    a_scan_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !$past(r_state == S_SCAN)) |-> (r_idx == '0 && r_nev == '0))
        else $error("scan did not start at the first timer");
`endif

endmodule
